### rtl/aenc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the 32-bit order-0 arithmetic encoder.
// No dependencies; used by arithmetic_encoder_32bit and its testbench.
package aenc_pkg;

    localparam int SYMBOL_COUNT = 256;
    localparam int COUNT_BITS   = 24;
    localparam int PENDING_MAX  = 255;
    localparam int MAX_SHIFTS   = 32;
    localparam int VALUE_BITS   = 24;

    localparam logic [31:0] HALF_POINT     = 32'h8000_0000;
    localparam logic [31:0] QUARTER_POINT  = 32'h4000_0000;
    localparam logic [31:0] THREE_QUARTERS = 32'hC000_0000;

    typedef struct packed {
        logic        kind;
        logic [7:0]  symbol;
        logic [8:0]  table_index;
        logic [23:0] table_value;
        logic        end_of_input;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       stream_end;
        logic       pending_overflow;
    } t_out_word;

    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_ENCODE = 1'b1;

endpackage

### rtl/arithmetic_encoder_32bit.sv
`timescale 1ns / 1ps
// Order-0 arithmetic encoder with a 32-bit interval and a loadable cumulative table.
// A load word is written to the table as it is accepted. An encode word runs three table
// reads (S_RD0, S_RD1, S_RD2) and a check, a serial shift-add multiply and restoring divide
// in aenc_muldiv and a fix-up step (S_FIX), then the renormalization steps, each emitting
// its coded bits one bit a cycle while the held byte can be retired, a flush and pad on the
// last word, and a closing step; o_stall stays high until then, so no new word is taken
// meanwhile. The table lives in a synchronous memory with per-entry valid bits, so no
// clearing pass follows reset. Depends on aenc_pkg, aenc_table, aenc_muldiv.
module arithmetic_encoder_32bit #(
    parameter int SYMBOL_COUNT = aenc_pkg::SYMBOL_COUNT,
    parameter int COUNT_BITS   = aenc_pkg::COUNT_BITS,
    parameter int PENDING_MAX  = aenc_pkg::PENDING_MAX
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  aenc_pkg::t_in_word  i_word,
    output logic                o_valid,
    input  logic                i_stall,
    output aenc_pkg::t_out_word o_word
);

    localparam int IW = $clog2(SYMBOL_COUNT + 1);
    localparam int SW = (COUNT_BITS < aenc_pkg::VALUE_BITS) ? COUNT_BITS : aenc_pkg::VALUE_BITS;
    localparam int TW = (SW > IW) ? SW : IW;
    localparam int PW = 33 + TW;
    localparam int PB = $clog2(PENDING_MAX + 1);
    localparam int HB = $clog2(aenc_pkg::MAX_SHIFTS + 1);

    typedef enum logic [11:0] {
        S_IDLE   = 12'b0000_0000_0001,
        S_RD0    = 12'b0000_0000_0010,
        S_RD1    = 12'b0000_0000_0100,
        S_RD2    = 12'b0000_0000_1000,
        S_CHK    = 12'b0000_0001_0000,
        S_MD     = 12'b0000_0010_0000,
        S_FIX    = 12'b0000_0100_0000,
        S_RENORM = 12'b0000_1000_0000,
        S_EMIT   = 12'b0001_0000_0000,
        S_FLUSH  = 12'b0010_0000_0000,
        S_PAD    = 12'b0100_0000_0000,
        S_DONE   = 12'b1000_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic [31:0] r_low, n_low, r_high, n_high;
    logic [PB-1:0] r_pend, n_pend;
    logic [7:0] r_acc, n_acc;
    logic [2:0] r_bits, n_bits;
    logic r_ovf, n_ovf;
    logic r_hold_vld, n_hold_vld;
    logic [7:0] r_hold_byte, n_hold_byte;
    logic r_hold_ovf, n_hold_ovf;
    logic r_out_vld, n_out_vld;
    aenc_pkg::t_out_word r_out, n_out;
    logic [HB-1:0] r_shift, n_shift;
    logic r_emit_bit, n_emit_bit, r_emit_first, n_emit_first, r_emit_flush, n_emit_flush;
    logic [7:0] r_sym;
    logic r_last;
    logic [TW-1:0] r_lo_c, r_hi_c, r_total;

    logic [IW-1:0] rd_addr;
    logic [TW-1:0] rd_data;
    logic tbl_we, md_start, md_done;
    logic [32:0] off_lo, off_hi, range;
    logic out_free, can_push, do_push, push_val;
    logic [7:0] acc_next;
    t_state after_enc;

    assign tbl_we = (r_state == S_IDLE) && i_valid && (i_word.kind == aenc_pkg::KIND_LOAD)
                    && (32'(i_word.table_index) <= SYMBOL_COUNT);

    always_comb begin
        case (r_state)
            S_RD0:   rd_addr = IW'(r_sym);
            S_RD1:   rd_addr = IW'(r_sym) + IW'(1);
            default: rd_addr = IW'(SYMBOL_COUNT);
        endcase
    end

    aenc_table #(
        .DEPTH(SYMBOL_COUNT + 1), .AW(IW), .DW(SW), .OW(TW)
    ) u_table (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_we(tbl_we),
        .i_waddr(IW'(i_word.table_index)), .i_wdata(SW'(i_word.table_value)),
        .i_raddr(rd_addr), .o_rdata(rd_data)
    );

    assign range = {1'b0, r_high} - {1'b0, r_low} + 33'd1;

    aenc_muldiv #(.TW(TW), .PW(PW)) u_muldiv (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(md_start), .i_range(range),
        .i_lo_c(r_lo_c), .i_hi_c(r_hi_c), .i_total(r_total),
        .o_done(md_done), .o_off_lo(off_lo), .o_off_hi(off_hi)
    );

    assign o_stall  = (r_state != S_IDLE);
    assign o_valid  = r_out_vld;
    assign o_word   = r_out;
    assign out_free = !r_out_vld || !i_stall;
    // A bit that completes a byte must be able to retire the held byte first.
    assign can_push = (r_bits != 3'd7) || !r_hold_vld || out_free;
    assign after_enc = r_last ? S_FLUSH : S_DONE;
    assign acc_next = r_acc | (push_val ? (8'h80 >> r_bits) : 8'h00);

    always_comb begin
        n_state = r_state;
        n_low = r_low;
        n_high = r_high;
        n_pend = r_pend;
        n_acc = r_acc;
        n_bits = r_bits;
        n_ovf = r_ovf;
        n_hold_vld = r_hold_vld;
        n_hold_byte = r_hold_byte;
        n_hold_ovf = r_hold_ovf;
        n_out_vld = r_out_vld && i_stall;
        n_out = r_out;
        n_shift = r_shift;
        n_emit_bit = r_emit_bit;
        n_emit_first = r_emit_first;
        n_emit_flush = r_emit_flush;
        md_start = 1'b0;
        do_push = 1'b0;
        push_val = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_valid && i_word.kind == aenc_pkg::KIND_ENCODE) begin
                    n_state = (32'(i_word.symbol) >= SYMBOL_COUNT)
                              ? (i_word.end_of_input ? S_FLUSH : S_DONE) : S_RD0;
                end
            end
            S_RD0: n_state = S_RD1;
            S_RD1: n_state = S_RD2;
            S_RD2: n_state = S_CHK;
            S_CHK: begin
                if (rd_data == '0 || r_lo_c >= r_hi_c || r_hi_c > rd_data) begin
                    n_state = after_enc;
                end else begin
                    md_start = 1'b1;
                    n_state = S_MD;
                end
            end
            S_MD: begin
                if (md_done) begin
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                if (off_hi <= off_lo) begin
                    n_state = after_enc;
                end else begin
                    n_high = 32'({1'b0, r_low} + off_hi - 33'd1);
                    n_low = 32'({1'b0, r_low} + off_lo);
                    n_shift = '0;
                    n_state = S_RENORM;
                end
            end
            S_RENORM: begin
                if (r_shift == HB'(aenc_pkg::MAX_SHIFTS)) begin
                    n_state = after_enc;
                end else if (r_high < aenc_pkg::HALF_POINT) begin
                    n_low = r_low << 1;
                    n_high = {r_high[30:0], 1'b1};
                    n_shift = r_shift + HB'(1);
                    n_emit_bit = 1'b0;
                    n_emit_first = 1'b1;
                    n_emit_flush = 1'b0;
                    n_state = S_EMIT;
                end else if (r_low >= aenc_pkg::HALF_POINT) begin
                    n_low = (r_low - aenc_pkg::HALF_POINT) << 1;
                    n_high = {r_high[30:0], 1'b1};
                    n_shift = r_shift + HB'(1);
                    n_emit_bit = 1'b1;
                    n_emit_first = 1'b1;
                    n_emit_flush = 1'b0;
                    n_state = S_EMIT;
                end else if (r_low >= aenc_pkg::QUARTER_POINT
                             && r_high < aenc_pkg::THREE_QUARTERS) begin
                    if (r_pend >= PB'(PENDING_MAX)) begin
                        n_pend = PB'(PENDING_MAX);
                        n_ovf = 1'b1;
                    end else begin
                        n_pend = r_pend + PB'(1);
                    end
                    n_low = (r_low - aenc_pkg::QUARTER_POINT) << 1;
                    n_high = {r_high[30:0] - aenc_pkg::QUARTER_POINT[30:0], 1'b1};
                    n_shift = r_shift + HB'(1);
                end else begin
                    n_state = after_enc;
                end
            end
            S_EMIT: begin
                push_val = r_emit_first ? r_emit_bit : !r_emit_bit;
                if (can_push) begin
                    do_push = 1'b1;
                    n_emit_first = 1'b0;
                    if (!r_emit_first) begin
                        n_pend = r_pend - PB'(1);
                    end
                    if ((r_emit_first && r_pend == '0) || (!r_emit_first && r_pend == PB'(1))) begin
                        n_state = r_emit_flush ? S_PAD : S_RENORM;
                    end
                end
            end
            S_FLUSH: begin
                if (r_pend >= PB'(PENDING_MAX)) begin
                    n_pend = PB'(PENDING_MAX);
                    n_ovf = 1'b1;
                end else begin
                    n_pend = r_pend + PB'(1);
                end
                n_emit_bit = (r_low >= aenc_pkg::QUARTER_POINT);
                n_emit_first = 1'b1;
                n_emit_flush = 1'b1;
                n_state = S_EMIT;
            end
            S_PAD: begin
                if (r_bits == 3'd0) begin
                    n_state = S_DONE;
                end else if (can_push) begin
                    do_push = 1'b1;
                end
            end
            S_DONE: begin
                if (!r_hold_vld || out_free) begin
                    if (r_hold_vld) begin
                        n_out_vld = 1'b1;
                        n_out = '{out_byte: r_hold_byte, run_last: 1'b1,
                                  stream_end: r_last, pending_overflow: r_hold_ovf};
                        n_hold_vld = 1'b0;
                    end
                    if (r_last) begin
                        n_low = '0;
                        n_high = '1;
                        n_pend = '0;
                        n_acc = '0;
                        n_bits = '0;
                        n_ovf = 1'b0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (do_push) begin
            if (r_bits == 3'd7) begin
                if (r_hold_vld) begin
                    n_out_vld = 1'b1;
                    n_out = '{out_byte: r_hold_byte, run_last: 1'b0,
                              stream_end: 1'b0, pending_overflow: r_hold_ovf};
                end
                n_hold_vld = 1'b1;
                n_hold_byte = acc_next;
                n_hold_ovf = r_ovf;
                n_acc = '0;
                n_bits = '0;
            end else begin
                n_acc = acc_next;
                n_bits = r_bits + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_low <= '0;
            r_high <= '1;
            r_pend <= '0;
            r_acc <= '0;
            r_bits <= '0;
            r_ovf <= 1'b0;
            r_hold_vld <= 1'b0;
            r_out_vld <= 1'b0;
            r_shift <= '0;
            r_emit_first <= 1'b0;
            r_emit_flush <= 1'b0;
        end else begin
            r_state <= n_state;
            r_low <= n_low;
            r_high <= n_high;
            r_pend <= n_pend;
            r_acc <= n_acc;
            r_bits <= n_bits;
            r_ovf <= n_ovf;
            r_hold_vld <= n_hold_vld;
            r_out_vld <= n_out_vld;
            r_shift <= n_shift;
            r_emit_first <= n_emit_first;
            r_emit_flush <= n_emit_flush;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hold_byte <= n_hold_byte;
        r_hold_ovf <= n_hold_ovf;
        r_out <= n_out;
        r_emit_bit <= n_emit_bit;
        if (r_state == S_IDLE && i_valid) begin
            r_sym <= i_word.symbol;
            r_last <= i_word.end_of_input;
        end
        if (r_state == S_RD1) begin
            r_lo_c <= rd_data;
        end
        if (r_state == S_RD2) begin
            r_hi_c <= rd_data;
        end
        if (r_state == S_CHK) begin
            r_total <= rd_data;
        end
    end

`ifndef NO_ASSERTIONS
    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= PB'(PENDING_MAX))
        else $error("pending count above its limit");
    a_idle_no_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_hold_vld)
        else $error("held word left behind at end of item");
    a_acc_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bits == 3'd0) |-> (r_acc == 8'd0))
        else $error("stale bits in empty byte accumulator");
    a_interval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RENORM) |-> (r_low <= r_high))
        else $error("coding interval inverted");
`endif

endmodule

### rtl/aenc_table.sv
`timescale 1ns / 1ps
// Cumulative frequency table: one synchronous memory with a registered read port.
// Entries never written read back as their own index. Depends on nothing.
module aenc_table #(
    parameter int DEPTH = 257,
    parameter int AW    = 9,
    parameter int DW    = 24,
    parameter int OW    = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [OW-1:0] o_rdata
);

    logic [DW-1:0]    mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [DW-1:0]    r_rd;
    logic             r_rd_vld;
    logic [AW-1:0]    r_rd_addr;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rd      <= mem[i_raddr];
        r_rd_addr <= i_raddr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            r_rd_vld <= r_vld[i_raddr];
        end
    end

    assign o_rdata = r_rd_vld ? OW'(r_rd) : OW'(r_rd_addr);

endmodule

### rtl/aenc_muldiv.sv
`timescale 1ns / 1ps
// Serial shift-add multiplier followed by a restoring divider, two lanes sharing
// one divisor: off = range * count / total for both symbol bounds. Depends on nothing.
module aenc_muldiv #(
    parameter int TW = 24,
    parameter int PW = 57
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [32:0]   i_range,
    input  logic [TW-1:0] i_lo_c,
    input  logic [TW-1:0] i_hi_c,
    input  logic [TW-1:0] i_total,
    output logic          o_done,
    output logic [32:0]   o_off_lo,
    output logic [32:0]   o_off_hi
);

    localparam int CW = $clog2(PW + 1);

    logic          r_busy;
    logic          r_div;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [TW-1:0] r_mlo, r_mhi;
    logic [PW-1:0] r_plo, r_phi;
    logic [TW:0]   r_rlo, r_rhi;
    logic [32:0]   r_qlo, r_qhi;

    logic [TW:0] rem_lo, rem_hi;
    logic        ge_lo, ge_hi;

    always_comb begin
        rem_lo = {r_rlo[TW-1:0], r_plo[PW-1]};
        rem_hi = {r_rhi[TW-1:0], r_phi[PW-1]};
        ge_lo  = rem_lo >= {1'b0, i_total};
        ge_hi  = rem_hi >= {1'b0, i_total};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_div  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_div  <= 1'b0;
                r_cnt  <= CW'(TW);
            end else if (r_busy) begin
                if (r_cnt == CW'(1)) begin
                    if (r_div) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end else begin
                        r_div <= 1'b1;
                        r_cnt <= CW'(PW);
                    end
                end else begin
                    r_cnt <= r_cnt - CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mlo <= i_lo_c;
            r_mhi <= i_hi_c;
            r_plo <= '0;
            r_phi <= '0;
            r_rlo <= '0;
            r_rhi <= '0;
            r_qlo <= '0;
            r_qhi <= '0;
        end else if (r_busy && !r_div) begin
            r_plo <= (r_plo << 1) + (r_mlo[TW-1] ? PW'(i_range) : '0);
            r_phi <= (r_phi << 1) + (r_mhi[TW-1] ? PW'(i_range) : '0);
            r_mlo <= r_mlo << 1;
            r_mhi <= r_mhi << 1;
        end else if (r_busy) begin
            r_plo <= r_plo << 1;
            r_phi <= r_phi << 1;
            r_rlo <= ge_lo ? rem_lo - {1'b0, i_total} : rem_lo;
            r_rhi <= ge_hi ? rem_hi - {1'b0, i_total} : rem_hi;
            r_qlo <= {r_qlo[31:0], ge_lo};
            r_qhi <= {r_qhi[31:0], ge_hi};
        end
    end

    assign o_done   = r_done;
    assign o_off_lo = r_qlo;
    assign o_off_hi = r_qhi;

endmodule

### verif/arithmetic_encoder_32bit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for arithmetic_encoder_32bit: directed table, pending saturation
// burst and random words; bytes are checked against a built-in coder or typed expected bytes. Depends on aenc_pkg.
module arithmetic_encoder_32bit_tb;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int DRAIN_CYCLES = 400;
    localparam int HOLD_CYCLES = 3000;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    aenc_pkg::t_in_word  i_word = '0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    aenc_pkg::t_out_word o_word;

    arithmetic_encoder_32bit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_word  (i_word),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_word  (o_word)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Coder state mirrored by the testbench.
    logic [23:0]         cum_counts [0:aenc_pkg::SYMBOL_COUNT];
    logic [31:0]         span_low;
    logic [31:0]         span_high;
    int                  pending_count;
    logic [7:0]          byte_acc;
    int                  bit_count;
    bit                  overflow_flag;
    aenc_pkg::t_out_word item_bytes[$];
    aenc_pkg::t_out_word byte_queue[$];

    int  error_count = 0;
    int  cycle_count = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  hold_request = 1'b0;
    bit  hold_done = 1'b0;
    int  hold_left = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
        error_count++;
    endtask

    task automatic clear_coder();
        span_low = 32'h0;
        span_high = 32'hFFFF_FFFF;
        pending_count = 0;
        byte_acc = 8'h0;
        bit_count = 0;
        overflow_flag = 1'b0;
    endtask

    task automatic emit_bit(input bit b);
        if (b) begin
            byte_acc[7 - bit_count] = 1'b1;
        end
        bit_count++;
        if (bit_count == 8) begin
            item_bytes.push_back('{byte_acc, 1'b0, 1'b0, overflow_flag});
            byte_acc = 8'h0;
            bit_count = 0;
        end
    endtask

    task automatic emit_with_pending(input bit b);
        emit_bit(b);
        while (pending_count > 0) begin
            emit_bit(!b);
            pending_count--;
        end
    endtask

    task automatic bump_pending();
        if (pending_count >= aenc_pkg::PENDING_MAX) begin
            pending_count = aenc_pkg::PENDING_MAX;
            overflow_flag = 1'b1;
        end else begin
            pending_count++;
        end
    endtask

    task automatic narrow_interval(input logic [7:0] sym);
        longint unsigned lo_c, hi_c, total, range, off_lo, off_hi;
        lo_c = cum_counts[sym];
        hi_c = cum_counts[sym + 1];
        total = cum_counts[aenc_pkg::SYMBOL_COUNT];
        if (total == 0 || lo_c >= hi_c || hi_c > total) begin
            return;
        end
        range = longint'(span_high) - longint'(span_low) + 1;
        off_lo = (range * lo_c) / total;
        off_hi = (range * hi_c) / total;
        if (off_hi <= off_lo) begin
            return;
        end
        span_high = 32'(longint'(span_low) + off_hi - 1);
        span_low = 32'(longint'(span_low) + off_lo);
        for (int s = 0; s < aenc_pkg::MAX_SHIFTS; s++) begin
            if (span_high < aenc_pkg::HALF_POINT) begin
                emit_with_pending(1'b0);
            end else if (span_low >= aenc_pkg::HALF_POINT) begin
                emit_with_pending(1'b1);
                span_low -= aenc_pkg::HALF_POINT;
                span_high -= aenc_pkg::HALF_POINT;
            end else if (span_low >= aenc_pkg::QUARTER_POINT
                         && span_high < aenc_pkg::THREE_QUARTERS) begin
                bump_pending();
                span_low -= aenc_pkg::QUARTER_POINT;
                span_high -= aenc_pkg::QUARTER_POINT;
            end else begin
                break;
            end
            span_low = span_low << 1;
            span_high = (span_high << 1) | 32'h1;
        end
    endtask

    // Works out the bytes one accepted word causes, leaving them in item_bytes.
    task automatic code_word(input aenc_pkg::t_in_word w);
        item_bytes.delete();
        if (w.kind == aenc_pkg::KIND_LOAD) begin
            if (w.table_index <= aenc_pkg::SYMBOL_COUNT) begin
                cum_counts[w.table_index] = w.table_value;
            end
            return;
        end
        narrow_interval(w.symbol);
        if (w.end_of_input) begin
            bump_pending();
            emit_with_pending(span_low >= aenc_pkg::QUARTER_POINT);
            while (bit_count != 0) begin
                emit_bit(1'b0);
            end
        end
        if (item_bytes.size() > 0) begin
            item_bytes[$].run_last = 1'b1;
            item_bytes[$].stream_end = w.end_of_input;
        end
        if (w.end_of_input) begin
            clear_coder();
        end
    endtask

    // Drives one word and waits until the block takes it.
    task automatic send_word(input aenc_pkg::t_in_word w, input int typed_count,
                             input aenc_pkg::t_out_word typed [2]);
        i_valid <= 1'b1;
        i_word <= w;
        do @(posedge i_clk); while (o_stall);
        code_word(w);
        if (typed_count >= 0) begin
            item_bytes.delete();
            for (int k = 0; k < typed_count; k++) begin
                item_bytes.push_back(typed[k]);
            end
        end
        foreach (item_bytes[k]) begin
            byte_queue.push_back(item_bytes[k]);
        end
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    function automatic aenc_pkg::t_in_word load_word(input int idx, input int val);
        aenc_pkg::t_in_word w;
        w = '0;
        w.kind = aenc_pkg::KIND_LOAD;
        w.table_index = 9'(idx);
        w.table_value = 24'(val);
        return w;
    endfunction

    function automatic aenc_pkg::t_in_word encode_word(input int sym, input bit last);
        aenc_pkg::t_in_word w;
        w = '0;
        w.kind = aenc_pkg::KIND_ENCODE;
        w.symbol = 8'(sym);
        w.end_of_input = last;
        return w;
    endfunction

    // Output checker.
    always @(posedge i_clk) begin
        aenc_pkg::t_out_word want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (byte_queue.size() == 0) begin
                report_mismatch("unexpected byte", o_word.out_byte, 0);
            end else begin
                want = byte_queue.pop_front();
                if (o_word.out_byte !== want.out_byte)
                    report_mismatch("out_byte", o_word.out_byte, want.out_byte);
                if (o_word.run_last !== want.run_last)
                    report_mismatch("run_last", o_word.run_last, want.run_last);
                if (o_word.stream_end !== want.stream_end)
                    report_mismatch("stream_end", o_word.stream_end, want.stream_end);
                if (o_word.pending_overflow !== want.pending_overflow)
                    report_mismatch("pending_overflow", o_word.pending_overflow,
                                    want.pending_overflow);
            end
        end
    end

    // Receiver: random stalls by phase, plus one long hold-off on request.
    always @(posedge i_clk) begin
        if (hold_request && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            i_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall <= (hold_left > 1);
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    typedef struct {
        aenc_pkg::t_in_word  w;
        int                  typed_count;
        aenc_pkg::t_out_word typed [2];
    } t_row;

    t_row rows[$];

    function automatic void add_row(input aenc_pkg::t_in_word w, input int n,
                                    input aenc_pkg::t_out_word a = '0,
                                    input aenc_pkg::t_out_word b = '0);
        t_row r;
        r.w = w;
        r.typed_count = n;
        r.typed[0] = a;
        r.typed[1] = b;
        rows.push_back(r);
    endfunction

    initial begin
        aenc_pkg::t_out_word none [2];
        aenc_pkg::t_in_word  w;
        int                  pick;
        none = '{default: '0};
        for (int i = 0; i <= aenc_pkg::SYMBOL_COUNT; i++) begin
            cum_counts[i] = 24'(i);
        end
        clear_coder();

        // Fresh uniform table: the first and the last symbol code to one plain byte each, then the flush byte 40.
        add_row(encode_word(0, 1), 2, '{8'h00, 1'b0, 1'b0, 1'b0}, '{8'h40, 1'b1, 1'b1, 1'b0});
        add_row(encode_word(255, 1), 2, '{8'hFF, 1'b0, 1'b0, 1'b0}, '{8'h40, 1'b1, 1'b1, 1'b0});
        add_row(load_word(511, 24'hFF_FFFF) | aenc_pkg::t_in_word'(1), 0);
        add_row(encode_word(7, 0), -1);
        add_row(encode_word(200, 1), -1);
        add_row(load_word(aenc_pkg::SYMBOL_COUNT, 0), 0);
        add_row(encode_word(3, 1), -1);
        add_row(load_word(aenc_pkg::SYMBOL_COUNT, 24'hFF_FFFF), 0);
        add_row(encode_word(10, 0), -1);
        add_row(encode_word(255, 1), -1);
        add_row(load_word(5, 3), 0);
        add_row(encode_word(4, 1), -1);
        add_row(load_word(aenc_pkg::SYMBOL_COUNT, 100), 0);
        add_row(encode_word(150, 0), -1);
        add_row(encode_word(50, 1), -1);
        add_row(load_word(aenc_pkg::SYMBOL_COUNT, 256), 0);
        add_row(load_word(5, 5), 0);
        add_row(load_word(1, 24'hFF_FFFF), 0);
        add_row(encode_word(0, 0), -1);
        add_row(load_word(1, 1), 0);
        add_row(encode_word(128, 0), -1);
        add_row(encode_word(64, 0), -1);
        add_row(encode_word(1, 1), -1);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[r]) begin
            send_word(rows[r].w, rows[r].typed_count, rows[r].typed);
        end

        // Symbol 1 takes a thin slice around the midpoint, so each one adds nineteen
        // pending bits and the counter saturates well before the flush.
        send_word(load_word(1, 524287), -1, none);
        send_word(load_word(2, 524289), -1, none);
        send_word(load_word(aenc_pkg::SYMBOL_COUNT, 1048576), -1, none);
        for (int i = 0; i < 16; i++) begin
            send_word(encode_word(1, 0), -1, none);
        end
        send_word(encode_word(0, 1), -1, none);
        send_word(load_word(1, 1), -1, none);
        send_word(load_word(2, 2), -1, none);
        send_word(load_word(aenc_pkg::SYMBOL_COUNT, aenc_pkg::SYMBOL_COUNT), -1, none);

        hold_request <= 1'b1;
        for (int n = 0; n < 264; n++) begin
            case (n / 66)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
                default: begin send_idle_pct = 37; recv_stall_pct = 37; end
            endcase
            pick = $urandom_range(99);
            if (pick < 15) begin
                w = load_word($urandom_range(1, aenc_pkg::SYMBOL_COUNT), 0);
                w.table_value = ($urandom_range(1)) ? 24'($urandom) :
                                24'(w.table_index + $urandom_range(3));
                if ($urandom_range(9) == 0) begin
                    w.table_index = 9'($urandom_range(aenc_pkg::SYMBOL_COUNT + 1, 511));
                end
                w.end_of_input = $urandom_range(1);
                w.symbol = 8'($urandom);
            end else if (pick < 20) begin
                // Restore one entry so the table drifts back toward usable shares.
                w = load_word($urandom_range(aenc_pkg::SYMBOL_COUNT), 0);
                w.table_value = (w.table_index == aenc_pkg::SYMBOL_COUNT) ?
                                24'(aenc_pkg::SYMBOL_COUNT) : 24'(w.table_index);
            end else begin
                w = encode_word($urandom, ($urandom_range(9) == 0));
                w.table_index = 9'($urandom);
                w.table_value = 24'($urandom);
            end
            send_word(w, -1, none);
        end
        i_valid <= 1'b0;

        while (byte_queue.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && byte_queue.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

### files.f
rtl/aenc_pkg.sv
rtl/aenc_table.sv
rtl/aenc_muldiv.sv
rtl/arithmetic_encoder_32bit.sv
verif/arithmetic_encoder_32bit_tb.sv
